/* sv/b2da_pkg.sv */
package b2da_pkg;

    localparam int VALUE_BITS_DEF = 64;
    localparam int MAX_DIGITS_DEF = 20;
    localparam int IN_DATA_W      = 64;
    localparam int OUT_DATA_W     = 8;
    localparam int ASCII_W        = 6;

    localparam logic [ASCII_W-1:0] ASCII_ZERO = 6'd48;
    localparam logic [ASCII_W-1:0] ASCII_NINE = 6'd57;

    // requests from the sequencer to the conversion unit
    typedef struct packed {
        logic load;
        logic digit_shift;
    } t_conv_ctrl;

    // status back from the conversion unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_conv_stat;

endpackage

/* sv/b2da_bcd_shift.sv */
module b2da_bcd_shift #(
    parameter int VALUE_BITS = b2da_pkg::VALUE_BITS_DEF,
    parameter int MAX_DIGITS = b2da_pkg::MAX_DIGITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [VALUE_BITS-1:0]  i_value,
    input  b2da_pkg::t_conv_ctrl   i_ctrl,
    output b2da_pkg::t_conv_stat   o_stat,
    output logic [3:0]             o_top_digit
);

    localparam int BCD_W = 4 * MAX_DIGITS;
    localparam int CNT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

    logic [VALUE_BITS-1:0] r_bin;
    logic [BCD_W-1:0]      r_bcd;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_busy;
    logic                  r_done;
    logic [BCD_W-1:0]      n_adj;

    // add-3 correction on every digit, then one shift per cycle while busy
    always_comb begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                n_adj[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end else begin
                n_adj[4*i +: 4] = r_bcd[4*i +: 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.load) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(VALUE_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_bin <= i_value;
            r_bcd <= '0;
        end else if (r_busy) begin
            // carry out of the top digit drops: result is modulo 10^MAX_DIGITS
            r_bcd <= {n_adj[BCD_W-2:0], r_bin[VALUE_BITS-1]};
            r_bin <= r_bin << 1;
        end else if (i_ctrl.digit_shift) begin
            r_bcd <= r_bcd << 4;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_top_digit = r_bcd[BCD_W-1 -: 4];

endmodule

/* sv/binary_to_decimal_ascii.sv */
// Converts one unsigned value to decimal ASCII text, most significant digit first, leading
// zeros suppressed, a zero value giving the single character '0'; o_m_tlast marks the last
// digit. Only the low VALUE_BITS bits of the input are used, and when MAX_DIGITS is too small
// for that range the value is taken modulo 10^MAX_DIGITS. Conversion is a bit-serial
// shift-and-add-3 over a BCD register, one input bit per cycle; then the digit positions are
// scanned out most significant first (leading zeros are skipped at one per cycle, emitted
// digits wait on i_m_tready). o_s_tready is high only between items, and the output
// register lets the next item be taken while the last digit waits.
module binary_to_decimal_ascii #(
    parameter int VALUE_BITS = b2da_pkg::VALUE_BITS_DEF,
    parameter int MAX_DIGITS = b2da_pkg::MAX_DIGITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [b2da_pkg::IN_DATA_W-1:0]  i_s_tdata,   // [63:0] value
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [b2da_pkg::OUT_DATA_W-1:0] o_m_tdata,   // [5:0] ascii_digit, [7:6] zero
    output logic                            o_m_tlast    // last_digit
);

    localparam int LEFT_W = $clog2(MAX_DIGITS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_EMIT
    } t_state;

    t_state                            r_state;
    logic [LEFT_W-1:0]                 r_left;
    logic                              r_seen;
    logic                              r_out_valid;
    logic [b2da_pkg::ASCII_W-1:0]      r_out_digit;
    logic                              r_out_last;

    b2da_pkg::t_conv_ctrl              conv_ctrl;
    b2da_pkg::t_conv_stat              conv_stat;
    logic [3:0]                        top_digit;
    logic                              in_fire;
    logic                              out_free;
    logic                              skip_zero;
    logic                              emit_now;

    assign in_fire   = i_s_tvalid && o_s_tready;
    assign out_free  = !r_out_valid || i_m_tready;
    assign skip_zero = (r_state == S_EMIT) && !r_seen && (top_digit == 4'd0)
                       && (r_left != LEFT_W'(1));
    assign emit_now  = (r_state == S_EMIT) && !skip_zero && out_free;

    assign conv_ctrl.load        = in_fire;
    assign conv_ctrl.digit_shift = skip_zero || emit_now;

    b2da_bcd_shift #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_bcd_shift (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (i_s_tdata[VALUE_BITS-1:0]),
        .i_ctrl      (conv_ctrl),
        .o_stat      (conv_stat),
        .o_top_digit (top_digit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_left      <= '0;
            r_seen      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit_now) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_state <= S_CONV;
                    end
                end
                S_CONV: begin
                    if (conv_stat.done) begin
                        r_state <= S_EMIT;
                        r_left  <= LEFT_W'(MAX_DIGITS);
                        r_seen  <= 1'b0;
                    end
                end
                S_EMIT: begin
                    if (skip_zero) begin
                        r_left <= r_left - 1'b1;
                    end else if (emit_now) begin
                        r_out_digit <= b2da_pkg::ASCII_ZERO + {2'b00, top_digit};
                        r_out_last  <= (r_left == LEFT_W'(1));
                        r_seen      <= 1'b1;
                        r_left      <= r_left - 1'b1;
                        if (r_left == LEFT_W'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(b2da_pkg::OUT_DATA_W - b2da_pkg::ASCII_W){1'b0}}, r_out_digit};
    assign o_m_tlast  = r_out_last;

    a_done_in_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        conv_stat.done |-> (r_state == S_CONV))
        else $error("conversion finished outside conversion phase");

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[5:0] >= b2da_pkg::ASCII_ZERO
                        && o_m_tdata[5:0] <= b2da_pkg::ASCII_NINE))
        else $error("emitted character is not a decimal digit");

    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_left != '0))
        else $error("digit scan ran past the buffer");

    a_unit_idle_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |-> !conv_stat.busy)
        else $error("item accepted while conversion unit busy");

endmodule

/* dv/binary_to_decimal_ascii_tb.sv */
`timescale 1ns / 1ps

module binary_to_decimal_ascii_tb;

    localparam int VALUE_BITS = b2da_pkg::VALUE_BITS_DEF;
    localparam int MAX_DIGITS = b2da_pkg::MAX_DIGITS_DEF;
    localparam logic [63:0] VALUE_MASK = (VALUE_BITS >= 64) ? {64{1'b1}} :
                                         ((64'd1 << VALUE_BITS) - 64'd1);
    localparam int N_RANDOM = 400;
    localparam int DRAIN_CYCLES = 100;

    typedef struct packed {
        logic [b2da_pkg::ASCII_W-1:0] ascii;
        logic                         last;
    } t_dec_char;

    logic                            i_clk;
    logic                            i_rst_n = 1'b0;
    logic                            i_s_tvalid = 1'b0;
    logic                            o_s_tready;
    logic [b2da_pkg::IN_DATA_W-1:0]  i_s_tdata = '0;
    logic                            o_m_tvalid;
    logic                            i_m_tready = 1'b0;
    logic [b2da_pkg::OUT_DATA_W-1:0] o_m_tdata;
    logic                            o_m_tlast;

    logic [63:0] pending_values[$];
    t_dec_char   expected_chars[$];
    int          mismatches = 0;

    // sender side idling
    int          src_hold = 0;
    // receiver side stalling
    int          sink_hold = 0;

    binary_to_decimal_ascii #(
        .VALUE_BITS(VALUE_BITS),
        .MAX_DIGITS(MAX_DIGITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // decimal text of one value, most significant digit first
    function automatic void queue_decimal_chars(input logic [63:0] raw);
        logic [63:0] v;
        logic [63:0] rem;
        logic [3:0]  digs[MAX_DIGITS];
        int          n;
        int          k;
        t_dec_char   c;
        v = raw & VALUE_MASK;
        for (n = 0; n == 0 || (v != 64'd0 && n < MAX_DIGITS); n++) begin
            rem = v % 64'd10;
            digs[n] = rem[3:0];
            v = v / 64'd10;
        end
        // truncated remainder can leave leading zeros
        while (n > 1 && digs[n-1] == 4'd0)
            n--;
        for (k = 0; k < n; k++) begin
            c.ascii = b2da_pkg::ASCII_ZERO + {2'b00, digs[n-1-k]};
            c.last  = (k == n - 1);
            expected_chars.push_back(c);
        end
    endfunction

    function automatic int draw_gap();
        return int'($urandom_range(0, 5));
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            src_hold   <= 0;
        end else begin
            if (i_s_tvalid && o_s_tready)
                queue_decimal_chars(i_s_tdata);
            if (i_s_tvalid && !o_s_tready) begin
                // keep the item on the bus
            end else if (src_hold != 0) begin
                src_hold   <= src_hold - 1;
                i_s_tvalid <= 1'b0;
            end else if (pending_values.size() > 0) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= pending_values.pop_front();
                src_hold   <= draw_gap();
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // monitor and checker
    always @(posedge i_clk) begin
        t_dec_char exp_c;
        int        w;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            sink_hold  <= 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (expected_chars.size() == 0) begin
                    $error("unexpected item: ascii_digit %0d last_digit %0b",
                           o_m_tdata[5:0], o_m_tlast);
                    mismatches++;
                end else begin
                    exp_c = expected_chars.pop_front();
                    if (o_m_tdata[5:0] !== exp_c.ascii) begin
                        $error("ascii_digit mismatch: expected %0d, actual %0d",
                               exp_c.ascii, o_m_tdata[5:0]);
                        mismatches++;
                    end
                    if (o_m_tdata[7:6] !== 2'b00) begin
                        $error("pad mismatch: expected %0d, actual %0d", 0, o_m_tdata[7:6]);
                        mismatches++;
                    end
                    if (o_m_tlast !== exp_c.last) begin
                        $error("last_digit mismatch: expected %0b, actual %0b",
                               exp_c.last, o_m_tlast);
                        mismatches++;
                    end
                end
                w = draw_gap();
                i_m_tready <= (w == 0);
                sink_hold  <= w;
            end else if (!i_m_tready) begin
                if (sink_hold <= 1) begin
                    i_m_tready <= 1'b1;
                    sink_hold  <= 0;
                end else begin
                    sink_hold <= sink_hold - 1;
                end
            end
        end
    end

    initial begin
        logic [63:0] pow10[20];
        logic [63:0] v;
        int          k;
        int          i;
        pow10[0] = 64'd1;
        for (k = 1; k < 20; k++)
            pow10[k] = pow10[k-1] * 64'd10;

        // directed: edges of the range, digit-count boundaries, upper bits
        pending_values.push_back(64'd0);
        pending_values.push_back(64'd1);
        pending_values.push_back(64'd9);
        pending_values.push_back(64'd10);
        pending_values.push_back(64'd99);
        pending_values.push_back(64'd100);
        pending_values.push_back(64'd999999999);
        pending_values.push_back(64'd1000000000);
        pending_values.push_back(64'hFFFF_FFFF);
        pending_values.push_back(64'h1_0000_0000);
        pending_values.push_back(64'd999999999999999999);
        pending_values.push_back(64'd1000000000000000000);
        pending_values.push_back(64'd9999999999999999999);
        pending_values.push_back(64'd10000000000000000000);
        pending_values.push_back(64'h8000_0000_0000_0000);
        pending_values.push_back(64'd1234567890123456789);
        pending_values.push_back(64'd10000000000000000009);
        pending_values.push_back(64'hAAAA_AAAA_AAAA_AAAA);
        pending_values.push_back(64'h5555_5555_5555_5555);
        pending_values.push_back(64'd18446744073709551610);
        pending_values.push_back(64'hFFFF_FFFF_FFFF_FFFF);

        for (i = 0; i < N_RANDOM; i++) begin
            case ($urandom_range(0, 3))
                0: v = {$urandom, $urandom};
                1: v = {$urandom, $urandom} >> $urandom_range(0, 63);
                2: begin
                    // just around a power of ten
                    k = $urandom_range(0, 19);
                    v = pow10[k] + 64'($urandom_range(0, 6)) - 64'd3;
                end
                default: v = 64'($urandom_range(0, 1000));
            endcase
            pending_values.push_back(v);
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_values.size() > 0 || i_s_tvalid || expected_chars.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #10ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
